/* design/assert_macros.svh */
// Assertion helpers used by the filter unit. Each macro expects signals named clk and rst_n
// to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABKF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ABKF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* design/abkf_pkg.sv */
`timescale 1ns / 1ps

package abkf_pkg;

    typedef logic signed [31:0] q_t;
    typedef logic signed [49:0] wide_t;
    typedef logic signed [63:0] prod_t;

    localparam q_t Q_MAX = 32'sh7FFFFFFF;
    localparam q_t Q_MIN = 32'sh80000000;

    function automatic q_t sat32(input wide_t v);
        q_t r;
        if (v > wide_t'(Q_MAX))
        begin
            r = Q_MAX;
        end
        else if (v < wide_t'(Q_MIN))
        begin
            r = Q_MIN;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q16.16 product rescaled with round half up: floor(p / 2^16) plus bit 15.
    function automatic wide_t qround(input prod_t p);
        return wide_t'($signed(p[63:16])) + wide_t'($signed({1'b0, p[15]}));
    endfunction

endpackage

/* design/angle_bias_kalman_filter_unit.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Two-state angle and gyro-bias Kalman filter in signed Q16.16. Each input transaction
// carries an accelerometer angle and a gyro rate; each produces exactly one output
// transaction with the updated, saturated angle estimate. A sequencer runs ten products
// through one bit-serial multiplier and two gains through one bit-serial divider, one at a
// time. A new sample is accepted only while the sequencer is idle, but a finished result
// may still be waiting in the output register at that time.
// The registers at APB byte offsets 0x0, 0x4, 0x8 and 0xC hold the sample period,
// angle noise, gyro noise and measurement noise; write them only while the filter is idle.
module angle_bias_kalman_filter_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         in_valid,
    output logic         in_stall,
    input  abkf_pkg::q_t accel_angle,
    input  abkf_pkg::q_t gyro_rate,
    output logic         out_valid,
    input  logic         out_stall,
    output abkf_pkg::q_t filtered_angle
);
    import abkf_pkg::*;

    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_ANOISE = 2'd1;
    localparam logic [1:0] REG_GNOISE = 2'd2;
    localparam logic [1:0] REG_MNOISE = 2'd3;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_RATE  = 5'd1;
    localparam logic [4:0] ST_ANG   = 5'd2;
    localparam logic [4:0] ST_DIFF  = 5'd3;
    localparam logic [4:0] ST_PAA   = 5'd4;
    localparam logic [4:0] ST_PAB   = 5'd5;
    localparam logic [4:0] ST_PBB   = 5'd6;
    localparam logic [4:0] ST_EVAR  = 5'd7;
    localparam logic [4:0] ST_K0    = 5'd8;
    localparam logic [4:0] ST_K1    = 5'd9;
    localparam logic [4:0] ST_UAA   = 5'd10;
    localparam logic [4:0] ST_UAB   = 5'd11;
    localparam logic [4:0] ST_UBA   = 5'd12;
    localparam logic [4:0] ST_UBB   = 5'd13;
    localparam logic [4:0] ST_UANG  = 5'd14;
    localparam logic [4:0] ST_UBIAS = 5'd15;
    localparam logic [4:0] ST_FIN   = 5'd16;

    logic [15:0] period_reg;
    logic [30:0] anoise_reg;
    logic [30:0] gnoise_reg;
    logic [30:0] mnoise_reg;

    logic [4:0]  state_reg;
    logic        busy_reg;
    logic        out_valid_reg;
    q_t          out_data_reg;

    q_t angle_reg, bias_reg, aa_reg, ab_reg, ba_reg, bb_reg;
    q_t accel_reg, gyro_reg, rate_reg, innov_reg, dot0_reg, negbb_reg;
    q_t e_reg, t0_reg, t1_reg, k0_reg, k1_reg;

    logic        cfg_wr;
    logic        is_mul, is_div;
    logic        mul_start, mul_done, div_start, div_done;
    logic        mul_fire, div_fire, fin_go;
    q_t          mul_a, mul_b, div_num, dt_q, quo;
    prod_t       prod;
    wide_t       qr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PERIOD: prdata = {16'd0, period_reg};
            REG_ANOISE: prdata = {1'b0, anoise_reg};
            REG_GNOISE: prdata = {1'b0, gnoise_reg};
            REG_MNOISE: prdata = {1'b0, mnoise_reg};
            default:    prdata = '0;
        endcase
    end

    assign dt_q = $signed({16'd0, period_reg});

    assign is_mul = (state_reg == ST_ANG) || (state_reg == ST_PAA) || (state_reg == ST_PAB)
                 || (state_reg == ST_PBB) || (state_reg == ST_UAA) || (state_reg == ST_UAB)
                 || (state_reg == ST_UBA) || (state_reg == ST_UBB) || (state_reg == ST_UANG)
                 || (state_reg == ST_UBIAS);
    assign is_div = (state_reg == ST_K0) || (state_reg == ST_K1);

    assign mul_start = is_mul && !busy_reg;
    assign div_start = is_div && !busy_reg;
    assign mul_fire  = busy_reg && mul_done;
    assign div_fire  = busy_reg && div_done;
    assign fin_go    = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);
    assign qr        = qround(prod);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_ANG:   begin mul_a = rate_reg;                   mul_b = dt_q;      end
            ST_PAA:   begin mul_a = dot0_reg;                   mul_b = dt_q;      end
            ST_PAB:   begin mul_a = negbb_reg;                  mul_b = dt_q;      end
            ST_PBB:   begin mul_a = $signed({1'b0, gnoise_reg}); mul_b = dt_q;     end
            ST_UAA:   begin mul_a = k0_reg;                     mul_b = t0_reg;    end
            ST_UAB:   begin mul_a = k0_reg;                     mul_b = t1_reg;    end
            ST_UBA:   begin mul_a = k1_reg;                     mul_b = t0_reg;    end
            ST_UBB:   begin mul_a = k1_reg;                     mul_b = t1_reg;    end
            ST_UANG:  begin mul_a = k0_reg;                     mul_b = innov_reg; end
            ST_UBIAS: begin mul_a = k1_reg;                     mul_b = innov_reg; end
            default:  begin mul_a = '0;                         mul_b = '0;        end
        endcase
    end

    assign div_num = (state_reg == ST_K1) ? ba_reg : aa_reg;

    abkf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    abkf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (e_reg),
        .done  (div_done),
        .quo   (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= 16'd328;
            anoise_reg    <= 31'd6554;
            gnoise_reg    <= 31'd6554;
            mnoise_reg    <= 31'd32768;
            state_reg     <= ST_IDLE;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            angle_reg     <= '0;
            bias_reg      <= '0;
            aa_reg        <= 32'sd65536;
            ab_reg        <= '0;
            ba_reg        <= '0;
            bb_reg        <= 32'sd65536;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    REG_PERIOD: period_reg <= pwdata[15:0];
                    REG_ANOISE: anoise_reg <= pwdata[30:0];
                    REG_GNOISE: gnoise_reg <= pwdata[30:0];
                    REG_MNOISE: mnoise_reg <= pwdata[30:0];
                    default:    ;
                endcase
            end

            if (out_valid_reg && !out_stall && !fin_go)
            begin
                out_valid_reg <= 1'b0;
            end

            if (is_mul || is_div)
            begin
                if (!busy_reg)
                begin
                    busy_reg <= 1'b1;
                end
                else if (mul_done || div_done)
                begin
                    busy_reg <= 1'b0;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_RATE;
                    end
                end
                ST_RATE:
                begin
                    state_reg <= ST_ANG;
                end
                ST_ANG:
                begin
                    if (mul_fire)
                    begin
                        angle_reg <= sat32(wide_t'(angle_reg) + qr);
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF:
                begin
                    state_reg <= ST_PAA;
                end
                ST_PAA:
                begin
                    if (mul_fire)
                    begin
                        aa_reg    <= sat32(wide_t'(aa_reg) + qr);
                        state_reg <= ST_PAB;
                    end
                end
                ST_PAB:
                begin
                    if (mul_fire)
                    begin
                        ab_reg    <= sat32(wide_t'(ab_reg) + qr);
                        ba_reg    <= sat32(wide_t'(ba_reg) + qr);
                        state_reg <= ST_PBB;
                    end
                end
                ST_PBB:
                begin
                    if (mul_fire)
                    begin
                        bb_reg    <= sat32(wide_t'(bb_reg) + qr);
                        state_reg <= ST_EVAR;
                    end
                end
                ST_EVAR:
                begin
                    state_reg <= ST_K0;
                end
                ST_K0:
                begin
                    if (div_fire)
                    begin
                        state_reg <= ST_K1;
                    end
                end
                ST_K1:
                begin
                    if (div_fire)
                    begin
                        state_reg <= ST_UAA;
                    end
                end
                ST_UAA:
                begin
                    if (mul_fire)
                    begin
                        aa_reg    <= sat32(wide_t'(aa_reg) - qr);
                        state_reg <= ST_UAB;
                    end
                end
                ST_UAB:
                begin
                    if (mul_fire)
                    begin
                        ab_reg    <= sat32(wide_t'(ab_reg) - qr);
                        state_reg <= ST_UBA;
                    end
                end
                ST_UBA:
                begin
                    if (mul_fire)
                    begin
                        ba_reg    <= sat32(wide_t'(ba_reg) - qr);
                        state_reg <= ST_UBB;
                    end
                end
                ST_UBB:
                begin
                    if (mul_fire)
                    begin
                        bb_reg    <= sat32(wide_t'(bb_reg) - qr);
                        state_reg <= ST_UANG;
                    end
                end
                ST_UANG:
                begin
                    if (mul_fire)
                    begin
                        angle_reg <= sat32(wide_t'(angle_reg) + qr);
                        state_reg <= ST_UBIAS;
                    end
                end
                ST_UBIAS:
                begin
                    if (mul_fire)
                    begin
                        bias_reg  <= sat32(wide_t'(bias_reg) + qr);
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (fin_go)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Working values of the current sample; every one is written before it is read.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            accel_reg <= accel_angle;
            gyro_reg  <= gyro_rate;
        end
        if (state_reg == ST_RATE)
        begin
            rate_reg <= sat32(wide_t'(gyro_reg) - wide_t'(bias_reg));
        end
        if (state_reg == ST_DIFF)
        begin
            innov_reg <= sat32(wide_t'(accel_reg) - wide_t'(angle_reg));
            dot0_reg  <= sat32(wide_t'($signed({1'b0, anoise_reg}))
                               - wide_t'(ab_reg) - wide_t'(ba_reg));
            negbb_reg <= sat32(-wide_t'(bb_reg));
        end
        if (state_reg == ST_EVAR)
        begin
            e_reg  <= sat32(wide_t'($signed({1'b0, mnoise_reg})) + wide_t'(aa_reg));
            t0_reg <= aa_reg;
            t1_reg <= ab_reg;
        end
        if (state_reg == ST_K0 && div_fire)
        begin
            k0_reg <= quo;
        end
        if (state_reg == ST_K1 && div_fire)
        begin
            k1_reg <= quo;
        end
        if (fin_go)
        begin
            out_data_reg <= angle_reg;
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign filtered_angle = out_data_reg;

    `ABKF_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_reg == ST_RATE)
    `ABKF_ASSERT_SAME(a_one_unit, mul_done, !div_done)
    `ABKF_ASSERT_NEXT(a_fin_loads, fin_go, out_valid && (filtered_angle == $past(angle_reg)))

endmodule

/* design/abkf_mul.sv */
`timescale 1ns / 1ps

// Signed 32x32 shift-add multiplier, one multiplier bit per cycle.
module abkf_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  abkf_pkg::q_t    a,
    input  abkf_pkg::q_t    b,
    output logic            done,
    output abkf_pkg::prod_t prod
);
    import abkf_pkg::*;

    q_t                 a_reg;
    logic signed [32:0] hi_reg;
    logic [31:0]        lo_reg;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [33:0] addend;
    logic signed [33:0] sum;

    // The top multiplier bit carries negative weight, so its partial product is subtracted.
    always_comb
    begin
        if (!lo_reg[0])
        begin
            addend = '0;
        end
        else if (cnt_reg == 5'd31)
        begin
            addend = -34'(a_reg);
        end
        else
        begin
            addend = 34'(a_reg);
        end
        sum = 34'(hi_reg) + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[33:1];
            lo_reg <= {sum[0], lo_reg[31:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg[31:0], lo_reg};

endmodule

/* design/abkf_div.sv */
`timescale 1ns / 1ps

// Gain divider: (num * 2^16) / den truncated toward zero, saturated, zero when den <= 0.
// Restoring division, one quotient bit per cycle over 48 bits.
module abkf_div (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  abkf_pkg::q_t num,
    input  abkf_pkg::q_t den,
    output logic         done,
    output abkf_pkg::q_t quo
);
    import abkf_pkg::*;

    logic [30:0] den_reg;
    logic [31:0] rem_reg;
    logic [47:0] sh_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        neg_reg;
    logic        zero_reg;
    logic [31:0] mag;
    logic [31:0] trial;
    logic        ge;

    assign mag   = num[31] ? (32'd0 - num) : num;
    assign trial = {rem_reg[30:0], sh_reg[47]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd47)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg  <= den[30:0];
            rem_reg  <= '0;
            sh_reg   <= {mag, 16'd0};
            neg_reg  <= num[31];
            zero_reg <= den[31] || (den == '0);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (trial - {1'b0, den_reg}) : trial;
            sh_reg  <= {sh_reg[46:0], ge};
        end
    end

    always_comb
    begin
        if (zero_reg)
        begin
            quo = '0;
        end
        else if (neg_reg)
        begin
            quo = (sh_reg > 48'h0000_8000_0000) ? Q_MIN : q_t'(48'd0 - sh_reg);
        end
        else
        begin
            quo = (sh_reg > 48'h0000_7FFF_FFFF) ? Q_MAX : q_t'(sh_reg);
        end
    end

    assign done = done_reg;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import abkf_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE_CYCLES = 600;

    typedef enum int
    {
        REG_SAMPLE_PERIOD = 0,
        REG_ANGLE_NOISE = 1,
        REG_GYRO_NOISE = 2,
        REG_MEASURE_NOISE = 3
    } reg_index_e;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid;
    logic in_stall;
    q_t accel_angle;
    q_t gyro_rate;
    logic out_valid;
    logic out_stall;
    q_t filtered_angle;

    // Filter state and register copies kept by the testbench.
    longint unsigned dt_reg, angle_noise_reg, gyro_noise_reg, meas_noise_reg;
    longint angle_est, bias_est, p_aa, p_ab, p_ba, p_bb;

    q_t expected_angles[$];
    int fail_count;
    longint cycle_count;
    bit gaps_enabled;

    angle_bias_kalman_filter_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .accel_angle(accel_angle), .gyro_rate(gyro_rate),
        .out_valid(out_valid), .out_stall(out_stall),
        .filtered_angle(filtered_angle)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Q16.16 product, rounded half up.
    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        return (p + 32768) >>> 16;
    endfunction

    function automatic longint fx_div(longint num, longint den);
        if (den <= 0)
        begin
            return 0;
        end
        return clamp32((num * 65536) / den);
    endfunction

    task automatic reset_filter_state();
        dt_reg = 328;
        angle_noise_reg = 6554;
        gyro_noise_reg = 6554;
        meas_noise_reg = 32768;
        angle_est = 0;
        bias_est = 0;
        p_aa = 65536;
        p_ab = 0;
        p_ba = 0;
        p_bb = 65536;
    endtask

    function automatic q_t predict_filtered_angle(q_t accel, q_t gyro);
        longint dt, rate, innov, dot0, neg_bb, e, k0, k1, t0, t1;
        dt = longint'(dt_reg);
        rate = clamp32(longint'(gyro) - bias_est);
        angle_est = clamp32(angle_est + fx_mul(rate, dt));
        innov = clamp32(longint'(accel) - angle_est);
        dot0 = clamp32(longint'(angle_noise_reg) - p_ab - p_ba);
        neg_bb = clamp32(-p_bb);
        p_aa = clamp32(p_aa + fx_mul(dot0, dt));
        p_ab = clamp32(p_ab + fx_mul(neg_bb, dt));
        p_ba = clamp32(p_ba + fx_mul(neg_bb, dt));
        p_bb = clamp32(p_bb + fx_mul(longint'(gyro_noise_reg), dt));
        e = clamp32(longint'(meas_noise_reg) + p_aa);
        k0 = fx_div(p_aa, e);
        k1 = fx_div(p_ba, e);
        t0 = p_aa;
        t1 = p_ab;
        p_aa = clamp32(p_aa - fx_mul(k0, t0));
        p_ab = clamp32(p_ab - fx_mul(k0, t1));
        p_ba = clamp32(p_ba - fx_mul(k1, t0));
        p_bb = clamp32(p_bb - fx_mul(k1, t1));
        angle_est = clamp32(angle_est + fx_mul(k0, innov));
        bias_est = clamp32(bias_est + fx_mul(k1, innov));
        return q_t'(angle_est);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_enabled || r < 65)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Mostly plausible IMU values, with a share spanning the full 32-bit range.
    function automatic q_t rand_angle();
        if ($urandom_range(0, 4) == 0)
        begin
            return q_t'($urandom);
        end
        return q_t'(int'($urandom_range(0, 180 * 65536)) - 90 * 65536);
    endfunction

    function automatic q_t rand_rate();
        if ($urandom_range(0, 4) == 0)
        begin
            return q_t'($urandom);
        end
        return q_t'(int'($urandom_range(0, 500 * 65536)) - 250 * 65536);
    endfunction

    task automatic send_sample(q_t accel, q_t gyro);
        int gap;
        accel_angle = accel;
        gyro_rate = gyro;
        in_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        expected_angles.push_back(predict_filtered_angle(accel, gyro));
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_angles.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(reg_index_e idx, logic [31:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 4'(idx * 4);
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_SAMPLE_PERIOD: dt_reg = value & 32'h0000FFFF;
            REG_ANGLE_NOISE: angle_noise_reg = value & 32'h7FFFFFFF;
            REG_GYRO_NOISE: gyro_noise_reg = value & 32'h7FFFFFFF;
            REG_MEASURE_NOISE: meas_noise_reg = value & 32'h7FFFFFFF;
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] dt, logic [31:0] qa, logic [31:0] qb,
                             logic [31:0] rm);
        write_register(REG_SAMPLE_PERIOD, dt);
        write_register(REG_ANGLE_NOISE, qa);
        write_register(REG_GYRO_NOISE, qb);
        write_register(REG_MEASURE_NOISE, rm);
    endtask

    task automatic test_field_extremes();
        send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_sample(32'sh80000000, 32'sh80000000);
        send_sample(32'sh7FFFFFFF, 32'sh80000000);
        send_sample(32'sh80000000, 32'sh7FFFFFFF);
        send_sample(0, 0);
        send_sample(-1, -1);
        send_sample(32'sh55555555, 32'shAAAAAAAA);
        send_sample(32'shAAAAAAAA, 32'sh55555555);
        send_sample(45 * 65536, 10 * 65536);
        send_sample(-45 * 65536, -10 * 65536);
        drain_results();
    endtask

    // A period written with only bit 16 set masks to zero, freezing the prediction.
    task automatic test_zero_period();
        configure(32'h0001_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0001);
        send_sample(30 * 65536, 100 * 65536);
        send_sample(-30 * 65536, -100 * 65536);
        send_sample(32'sh7FFFFFFF, 32'sh80000000);
        drain_results();
    endtask

    task automatic test_config_extremes();
        configure(32'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
        send_sample(32'sh7FFFFFFF, 32'sh80000000);
        send_sample(32'sh80000000, 32'sh7FFFFFFF);
        send_sample(0, 0);
        drain_results();
        configure(1, 0, 0, 32'h7FFF_FFFF);
        send_sample(90 * 65536, 250 * 65536);
        send_sample(-90 * 65536, -250 * 65536);
        send_sample(0, 0);
        drain_results();
    endtask

    task automatic test_random_traffic(int count, bit with_gaps, bit mid_pause);
        gaps_enabled = with_gaps;
        for (int i = 0; i < count; i++)
        begin
            if (mid_pause && i == count / 2)
            begin
                // Hold the input until every outstanding result has returned.
                drain_results();
            end
            send_sample(rand_angle(), rand_rate());
        end
        drain_results();
        gaps_enabled = 1'b1;
    endtask

    task automatic test_random_configs();
        configure(328, 6554, 6554, 32768);
        test_random_traffic(200, 1'b1, 1'b1);
        configure($urandom, $urandom, $urandom, $urandom_range(1, 32'h7FFF_FFFF));
        test_random_traffic(150, 1'b0, 1'b0);
        configure(32'hFFFF, 32'h7FFF_FFFF, 0, 1);
        test_random_traffic(150, 1'b1, 1'b0);
        configure(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        test_random_traffic(150, 1'b1, 1'b0);
        configure($urandom_range(1, 2000), $urandom_range(0, 200000),
                  $urandom_range(0, 200000), $urandom_range(1, 200000));
        test_random_traffic(150, 1'b1, 1'b0);
        configure(32'hFFFF_0000 | $urandom, $urandom, $urandom, $urandom);
        test_random_traffic(130, 1'b1, 1'b0);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n || !gaps_enabled)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < 30) ||
                         ($urandom_range(0, 199) == 0);
        end
    end

    always @(posedge clk)
    begin
        q_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_angles.size() == 0)
            begin
                $error("filtered_angle: no result expected, actual %0d", filtered_angle);
                fail_count++;
            end
            else
            begin
                want = expected_angles.pop_front();
                if (filtered_angle !== want)
                begin
                    $error("filtered_angle: expected %0d, actual %0d", want, filtered_angle);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        fail_count = 0;
        cycle_count = 0;
        gaps_enabled = 1'b1;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        accel_angle = '0;
        gyro_rate = '0;
        reset_filter_state();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        repeat (SETTLE_CYCLES) @(negedge clk);

        test_field_extremes();
        test_zero_period();
        test_config_extremes();
        test_random_configs();

        if (expected_angles.size() != 0)
        begin
            $error("filtered_angle: %0d results never arrived", expected_angles.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
